/* hdl/tdm_pkg.sv */
// Package of the table-driven DFA matcher: opcodes, character constants,
// field widths and FSM states. No dependencies.
`timescale 1ns / 1ps

package tdm_pkg;

  localparam int StateW      = 10;
  localparam int SymW        = 8;
  localparam int SymCount    = 256;
  localparam int MaxStates   = 1024;
  localparam int MaxClasses  = 64;
  localparam int InDataW     = 32;
  localparam int OutDataW    = 16;

  localparam logic [SymW-1:0] CharCaret = 8'h5E;
  localparam logic [SymW-1:0] CharSpace = 8'h20;
  localparam logic [SymW-1:0] CharBar   = 8'h7C;
  localparam logic [SymW-1:0] CharNl    = 8'h0A;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_WILD    = 2'd1,
    OP_RESTART = 2'd2,
    OP_TEXT    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_READ,
    ST_WILD,
    ST_RESULT
  } state_e;

endpackage

/* hdl/tdm_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module tdm_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/table_driven_dfa_matcher.sv */
// Table-driven DFA matcher with loadable transition store and class map; uses tdm_pkg, tdm_ram.
// Restart, newline and ignored loads go straight to the result; a transition load passes a
// lookup state; a text byte reads the class map, then the store; a wildcard or caret load
// writes every class column. One item in flight; the next is accepted the cycle after the
// result is registered. After reset the store is swept to zero, one entry a cycle:
// MAX_CLASSES * 2**min(10, clog2(MAX_STATES)) entries, 65536 at defaults.
`timescale 1ns / 1ps

module table_driven_dfa_matcher #(
  parameter int MAX_STATES  = tdm_pkg::MaxStates,
  parameter int MAX_CLASSES = tdm_pkg::MaxClasses
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [1:0] opcode, [11:2] source_state, [19:12] symbol, [29:20] target_state
  input  logic [tdm_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [9:0] current_state, [10] error
  output logic [tdm_pkg::OutDataW-1:0]  m_axis_tdata
);

  import tdm_pkg::*;

  localparam int StW        = $clog2(MAX_STATES);
  localparam int RowW       = (StW > StateW) ? StateW : StW;
  localparam int ClsW       = $clog2(MAX_CLASSES);
  localparam int StoreAw    = ClsW + RowW;
  localparam int StoreDepth = MAX_CLASSES * (2 ** RowW);

  state_e state_q, state_d;

  op_e               op_q, op_d;
  logic [StateW-1:0] src_q, src_d;
  logic [SymW-1:0]   sym_q, sym_d;
  logic [StateW-1:0] dst_q, dst_d;
  logic [StateW-1:0] match_q, match_d;
  logic              err_q, err_d;
  logic [ClsW-1:0]   cnt_q, cnt_d;
  logic [ClsW-1:0]   col_q, col_d;
  logic [StoreAw-1:0] clr_q, clr_d;
  logic [SymCount-1:0] vld_q, vld_d;
  logic              out_vld_q, out_vld_d;
  logic [StateW-1:0] out_st_q, out_st_d;
  logic              out_err_q, out_err_d;

  op_e               in_op;
  logic [StateW-1:0] in_src;
  logic [SymW-1:0]   in_sym;
  logic [StateW-1:0] in_dst;
  logic [SymW-1:0]   in_ch;
  logic              in_fire;
  logic              in_range;

  logic               st_we, st_re;
  logic [StoreAw-1:0] st_waddr, st_raddr;
  logic [StateW-1:0]  st_wdata, st_rdata;
  logic               cm_we, cm_re;
  logic [SymW-1:0]    cm_waddr, cm_raddr;
  logic [ClsW-1:0]    cm_wdata, cm_rdata;
  logic [ClsW-1:0]    text_cls;
  logic               out_load;

  assign in_op    = op_e'(s_axis_tdata[1:0]);
  assign in_src   = s_axis_tdata[11:2];
  assign in_sym   = s_axis_tdata[19:12];
  assign in_dst   = s_axis_tdata[29:20];
  assign in_ch    = (in_op == OP_TEXT && in_sym == CharSpace) ? CharBar : in_sym;
  assign in_range = (int'(in_src) < MAX_STATES) && (int'(in_dst) < MAX_STATES);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_RESULT) && (!out_vld_q || m_axis_tready);
  assign text_cls      = vld_q[sym_q] ? cm_rdata : cnt_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == StoreAw'(StoreDepth - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_RESTART: state_d = ST_RESULT;
            OP_TEXT:    state_d = (in_sym == CharNl) ? ST_RESULT : ST_LOOK;
            OP_ADD, OP_WILD: begin
              if (!in_range) state_d = ST_RESULT;
              else if (in_op == OP_WILD || in_sym == CharCaret) state_d = ST_WILD;
              else state_d = ST_LOOK;
            end
            default: state_d = ST_RESULT;
          endcase
        end
      end
      ST_LOOK:   state_d = (op_q == OP_TEXT) ? ST_READ : ST_RESULT;
      ST_READ:   state_d = ST_RESULT;
      ST_WILD: begin
        if (col_q == ClsW'(MAX_CLASSES - 1)) state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_load) state_d = ST_IDLE;
      end
      default:   state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    op_d      = op_q;
    src_d     = src_q;
    sym_d     = sym_q;
    dst_d     = dst_q;
    match_d   = match_q;
    err_d     = err_q;
    cnt_d     = cnt_q;
    col_d     = col_q;
    clr_d     = clr_q;
    vld_d     = vld_q;
    out_vld_d = out_vld_q && !m_axis_tready;
    out_st_d  = out_st_q;
    out_err_d = out_err_q;
    st_we     = 1'b0;
    st_waddr  = {ClsW'(0), src_q[RowW-1:0]};
    st_wdata  = dst_q;
    st_re     = 1'b0;
    st_raddr  = {text_cls, match_q[RowW-1:0]};
    cm_we     = 1'b0;
    cm_waddr  = sym_q;
    cm_wdata  = cnt_q;
    cm_re     = 1'b0;
    cm_raddr  = in_ch;
    case (state_q)
      ST_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clr_q;
        st_wdata = '0;
        clr_d    = clr_q + StoreAw'(1);
      end
      ST_IDLE: begin
        if (in_fire) begin
          op_d  = in_op;
          src_d = in_src;
          sym_d = in_ch;
          dst_d = in_dst;
          err_d = 1'b0;
          col_d = '0;
          cm_re = 1'b1;
          if (in_op == OP_RESTART) match_d = '0;
        end
      end
      ST_LOOK: begin
        if (op_q == OP_TEXT) begin
          st_re = 1'b1;
        end else if (vld_q[sym_q]) begin
          st_we    = 1'b1;
          st_waddr = {cm_rdata, src_q[RowW-1:0]};
        end else if (cnt_q < ClsW'(MAX_CLASSES - 1)) begin
          st_we        = 1'b1;
          st_waddr     = {cnt_q, src_q[RowW-1:0]};
          cm_we        = 1'b1;
          vld_d[sym_q] = 1'b1;
          cnt_d        = cnt_q + ClsW'(1);
        end else begin
          err_d = 1'b1;
        end
      end
      ST_READ: begin
        match_d = st_rdata;
      end
      ST_WILD: begin
        st_we    = 1'b1;
        st_waddr = {col_q, src_q[RowW-1:0]};
        col_d    = col_q + ClsW'(1);
      end
      ST_RESULT: begin
        if (out_load) begin
          out_vld_d = 1'b1;
          out_st_d  = match_q;
          out_err_d = err_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      match_q   <= '0;
      err_q     <= 1'b0;
      cnt_q     <= '0;
      col_q     <= '0;
      clr_q     <= '0;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      match_q   <= match_d;
      err_q     <= err_d;
      cnt_q     <= cnt_d;
      col_q     <= col_d;
      clr_q     <= clr_d;
      vld_q     <= vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    src_q     <= src_d;
    sym_q     <= sym_d;
    dst_q     <= dst_d;
    out_st_q  <= out_st_d;
    out_err_q <= out_err_d;
  end

  tdm_ram #(
    .Width (StateW),
    .Depth (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  tdm_ram #(
    .Width (ClsW),
    .Depth (SymCount)
  ) u_class_map (
    .clk_i   (clk_i),
    .we_i    (cm_we),
    .waddr_i (cm_waddr),
    .wdata_i (cm_wdata),
    .re_i    (cm_re),
    .raddr_i (cm_raddr),
    .rdata_o (cm_rdata)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(OutDataW - StateW - 1)'(0), out_err_q, out_st_q};

  a_class_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(vld_q) == int'(cnt_q))
    else $error("class count differs from mapped characters");

  a_item_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != ST_IDLE && state_q != ST_CLEAR)
    else $error("accepted item not in progress");

  a_read_after_look : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> $past(state_q) == ST_LOOK && op_q == OP_TEXT)
    else $error("store read without class lookup");

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for table_driven_dfa_matcher: a scoreboard class predicts
// every result word and random sender and receiver stalls exercise the stream handshake.
// Depends on tdm_pkg and the matcher RTL.
`timescale 1ns / 1ps

module tb_top;
  import tdm_pkg::*;

  class dfa_scoreboard;
    logic [StateW-1:0]   next_state_tbl [MaxClasses][MaxStates];
    logic [6:0]          class_of [SymCount];
    bit                  class_known [SymCount];
    int unsigned         class_cnt;
    logic [StateW-1:0]   match_st;
    logic [OutDataW-1:0] expected_q [$];
    int unsigned         fail_cnt;
    int unsigned         op_cnt [4];
    int unsigned         full_cnt;

    function new();
      foreach (next_state_tbl[c, s]) next_state_tbl[c][s] = '0;
      foreach (class_known[i]) begin
        class_known[i] = 1'b0;
        class_of[i]    = '0;
      end
      foreach (op_cnt[i]) op_cnt[i] = 0;
      class_cnt = 0;
      match_st  = '0;
      fail_cnt  = 0;
      full_cnt  = 0;
    endfunction

    function void note_word(op_e op, logic [StateW-1:0] src, logic [SymW-1:0] sym,
                            logic [StateW-1:0] dst);
      logic              err;
      logic [SymW-1:0]   ch;
      int unsigned       col;
      err = 1'b0;
      op_cnt[op]++;
      case (op)
        OP_ADD, OP_WILD: begin
          if (op == OP_WILD || sym == CharCaret) begin
            for (int c = 0; c < MaxClasses; c++) next_state_tbl[c][src] = dst;
          end else if (class_known[sym]) begin
            next_state_tbl[class_of[sym]][src] = dst;
          end else if (class_cnt < MaxClasses - 1) begin
            class_of[sym]    = class_cnt[6:0];
            class_known[sym] = 1'b1;
            next_state_tbl[class_cnt][src] = dst;
            class_cnt++;
          end else begin
            err = 1'b1;
            full_cnt++;
          end
        end
        OP_RESTART: match_st = '0;
        default: begin
          if (sym != CharNl) begin
            ch  = (sym == CharSpace) ? CharBar : sym;
            col = class_known[ch] ? class_of[ch] : class_cnt;
            match_st = next_state_tbl[col][match_st];
          end
        end
      endcase
      expected_q.push_back({5'd0, err, match_st});
    endfunction

    function void check_word(logic [OutDataW-1:0] got);
      logic [OutDataW-1:0] exp_w;
      if (expected_q.size() == 0) begin
        $error("result word 0x%04h arrived with nothing expected", got);
        fail_cnt++;
        return;
      end
      exp_w = expected_q.pop_front();
      if (got[StateW-1:0] !== exp_w[StateW-1:0]) begin
        $error("current_state: expected %0d, got %0d", exp_w[StateW-1:0], got[StateW-1:0]);
        fail_cnt++;
      end
      if (got[StateW] !== exp_w[StateW]) begin
        $error("error: expected %0d, got %0d", exp_w[StateW], got[StateW]);
        fail_cnt++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  bit                  idle_on;
  logic [SymW-1:0]     loaded_syms [$];
  dfa_scoreboard       sb;

  table_driven_dfa_matcher i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #8ms;
    $display("tb_top failed");
    $finish;
  end

  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(1, 9) - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
  end

  task automatic push_word(input op_e op, input logic [StateW-1:0] src,
                           input logic [SymW-1:0] sym, input logic [StateW-1:0] dst);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, dst, sym, src, op};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(op, src, sym, dst);
    if (op == OP_ADD) loaded_syms.push_back(sym);
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [StateW-1:0] pick_state();
    if ($urandom_range(0, 99) < 85) return StateW'($urandom_range(0, 15));
    return StateW'($urandom_range(0, MaxStates - 1));
  endfunction

  function automatic logic [SymW-1:0] pick_symbol();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55 && loaded_syms.size() != 0)
      return loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
    if (r < 70) begin
      case ($urandom_range(0, 3))
        0:       return CharSpace;
        1:       return CharNl;
        2:       return CharBar;
        default: return CharCaret;
      endcase
    end
    return SymW'($urandom_range(0, SymCount - 1));
  endfunction

  initial begin
    op_e op;
    int  r;
    sb = new();
    idle_on = 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    rst_ni        <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_word(OP_TEXT,    10'd0,    8'h61,     10'd0);
    push_word(OP_ADD,     10'd0,    8'h61,     10'd5);
    push_word(OP_ADD,     10'd5,    8'h62,     10'd1023);
    push_word(OP_ADD,     10'd1023, 8'h00,     10'd512);
    push_word(OP_ADD,     10'd512,  8'hFF,     10'h155);
    push_word(OP_WILD,    10'd7,    8'hAA,     10'd3);
    push_word(OP_ADD,     10'd3,    CharCaret, 10'h2AA);
    push_word(OP_ADD,     10'd0,    CharBar,   10'd9);
    push_word(OP_TEXT,    10'h3FF,  8'h61,     10'h3FF);
    push_word(OP_TEXT,    10'd0,    8'h62,     10'd0);
    push_word(OP_TEXT,    10'd0,    CharNl,    10'd0);
    push_word(OP_TEXT,    10'd0,    8'h00,     10'd0);
    push_word(OP_TEXT,    10'd0,    8'hFF,     10'd0);
    push_word(OP_TEXT,    10'd0,    8'hC3,     10'd0);
    push_word(OP_RESTART, 10'h3FF,  8'hFF,     10'h3FF);
    push_word(OP_TEXT,    10'd0,    CharSpace, 10'd0);
    push_word(OP_RESTART, 10'd0,    8'h00,     10'd0);
    push_word(OP_TEXT,    10'd0,    CharBar,   10'd0);
    push_word(OP_ADD,     10'd0,    8'h61,     10'd2);
    push_word(OP_WILD,    10'd0,    8'h00,     10'd7);
    push_word(OP_RESTART, 10'd0,    8'h00,     10'd0);
    push_word(OP_TEXT,    10'd0,    8'h55,     10'd0);
    push_word(OP_TEXT,    10'd0,    8'h61,     10'd0);
    push_word(OP_TEXT,    10'd0,    8'h62,     10'd0);
    hold_until_drained();

    for (int n = 0; n < 1400; n++) begin
      if (n % 100 == 0) idle_on = (n < 1250) && ($urandom_range(0, 3) != 0);
      if (n == 700) hold_until_drained();
      r = $urandom_range(0, 99);
      if (r < 30)      op = OP_ADD;
      else if (r < 33) op = OP_WILD;
      else if (r < 40) op = OP_RESTART;
      else             op = OP_TEXT;
      if (op == OP_RESTART)
        push_word(op, StateW'($urandom_range(0, MaxStates - 1)),
                  SymW'($urandom_range(0, SymCount - 1)),
                  StateW'($urandom_range(0, MaxStates - 1)));
      else
        push_word(op, pick_state(), pick_symbol(), pick_state());
    end
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (MaxClasses + 16) @(posedge clk_i);

    $display("run covered %0d transition loads, %0d wildcard loads, %0d restarts, %0d text words",
             sb.op_cnt[OP_ADD], sb.op_cnt[OP_WILD], sb.op_cnt[OP_RESTART], sb.op_cnt[OP_TEXT]);
    $display("%0d classes handed out, %0d loads refused with no class left",
             sb.class_cnt, sb.full_cnt);
    if (sb.fail_cnt == 0 && sb.expected_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

/* table_driven_dfa_matcher.f */
hdl/tdm_pkg.sv
hdl/tdm_ram.sv
hdl/table_driven_dfa_matcher.sv
tb/sv/tb_top.sv
